/* hw/rtl/gdss_pkg.sv */
`default_nettype none

package gdss_pkg;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        CFG_SMOOTH_MODE   = 2'd0,
        CFG_TALL_FONT     = 2'd1,
        CFG_INVERT_OUTPUT = 2'd2
    } cfg_index_t;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int COL_W           = 16;
    localparam int COPY_W          = 2 * COL_W;

    typedef struct packed {
        logic [15:0] column_bits;
        logic        last_column;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } out_item_t;

    typedef struct packed {
        logic smooth_mode;
        logic tall_font;
        logic invert_output;
    } cfg_t;

    // One queued job: two or four copies, sent in order from copies[0]
    typedef struct packed {
        logic                   two_pairs;
        logic [3:0][COPY_W-1:0] copies;
    } job_t;

    // Vertical doubling: bit k goes to bits 2k and 2k+1
    function automatic logic [COPY_W-1:0] spread_bits(input logic [COL_W-1:0] v);
        logic [COPY_W-1:0] s;
        s = '0;
        for (int k = 0; k < COL_W; k++)
        begin
            s[2*k]     = v[k];
            s[2*k + 1] = v[k];
        end
        return s;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/gdss_fifo.sv */
`default_nettype none

module gdss_fifo
    import gdss_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire  logic clk,
    input  wire  logic rst_n,
    input  wire  logic push,
    input  wire  job_t push_data,
    input  wire  logic pop,
    output job_t       head,
    output logic       full,
    output logic       empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign head  = entry_reg[rd_ptr_reg];
    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("job queue underflow");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("job queue count out of range");
`endif

endmodule

`default_nettype wire

/* hw/rtl/gdss_front.sv */
`default_nettype none

module gdss_front
    import gdss_pkg::*;
(
    input  wire  logic     clk,
    input  wire  logic     rst_n,
    input  wire  cfg_t     cfg,
    input  wire  logic     in_valid,
    output logic           in_ready,
    input  wire  in_item_t in_data,
    input  wire  logic     q_full,
    output logic           q_push,
    output job_t           q_data
);

    logic [COL_W-1:0]  prev_bits_reg,      prev_bits_next;
    logic [COPY_W-1:0] prev_left_copy_reg, prev_left_copy_next;
    logic              have_prev_reg,      have_prev_next;

    logic              accept;
    logic [COL_W-1:0]  col;
    logic [COPY_W-1:0] plain_cur;
    logic [COPY_W-1:0] plain_prev;
    logic [COPY_W-1:0] cur_left;
    logic [COPY_W-1:0] held_right;
    logic              has_new;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Masking, doubling and diagonal fill between held and new column
    always_comb
    begin
        col        = {cfg.tall_font ? in_data.column_bits[15:8] : 8'h00,
                      in_data.column_bits[7:0]};
        plain_cur  = spread_bits(col);
        plain_prev = spread_bits(prev_bits_reg);
        cur_left   = plain_cur;
        held_right = plain_prev;
        if (have_prev_reg)
        begin
            for (int i = 0; i < COL_W - 1; i++)
            begin
                // held falls while new rises: step down to the right
                if (prev_bits_reg[i+1] && !prev_bits_reg[i] && col[i] && !col[i+1])
                begin
                    held_right[2*i + 1] = 1'b1;
                    cur_left[2*i + 2]   = 1'b1;
                end
                else if (!prev_bits_reg[i+1] && prev_bits_reg[i] && !col[i] && col[i+1])
                begin
                    held_right[2*i + 2] = 1'b1;
                    cur_left[2*i + 1]   = 1'b1;
                end
            end
        end
    end

    // Job building and hold update
    always_comb
    begin
        has_new = !cfg.smooth_mode || in_data.last_column;
        q_data  = '0;
        if (have_prev_reg)
        begin
            q_data.copies[0] = prev_left_copy_reg;
            q_data.copies[1] = cfg.smooth_mode ? held_right : plain_prev;
            q_data.copies[2] = cfg.smooth_mode ? cur_left : plain_cur;
            q_data.copies[3] = plain_cur;
            q_data.two_pairs = has_new;
        end
        else
        begin
            q_data.copies[0] = cfg.smooth_mode ? cur_left : plain_cur;
            q_data.copies[1] = plain_cur;
            q_data.two_pairs = 1'b0;
        end
        q_push = accept && (have_prev_reg || has_new);

        prev_bits_next      = prev_bits_reg;
        prev_left_copy_next = prev_left_copy_reg;
        have_prev_next      = have_prev_reg;
        if (accept)
        begin
            if (cfg.smooth_mode)
            begin
                prev_bits_next      = col;
                prev_left_copy_next = cur_left;
                have_prev_next      = !in_data.last_column;
            end
            else
            begin
                have_prev_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_bits_reg      <= '0;
            prev_left_copy_reg <= '0;
            have_prev_reg      <= 1'b0;
        end
        else
        begin
            prev_bits_reg      <= prev_bits_next;
            prev_left_copy_reg <= prev_left_copy_next;
            have_prev_reg      <= have_prev_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/gdss_back.sv */
`default_nettype none

module gdss_back
    import gdss_pkg::*;
(
    input  wire  logic clk,
    input  wire  logic rst_n,
    input  wire  cfg_t cfg,
    input  wire  logic q_empty,
    input  wire  job_t q_head,
    output logic       q_pop,
    output logic       out_valid,
    input  wire  logic out_ready,
    output out_item_t  out_data
);

    logic [1:0]  byte_reg,      byte_next;
    logic [1:0]  copy_reg,      copy_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg,  out_data_next;

    logic              load;
    logic              copy_done;
    logic              job_done;
    logic [COPY_W-1:0] word;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Byte serializer: least significant byte of each copy first
    always_comb
    begin
        load      = !q_empty && (!out_valid_reg || out_ready);
        copy_done = (byte_reg == (cfg.tall_font ? 2'd3 : 2'd1));
        job_done  = copy_done && (copy_reg == (q_head.two_pairs ? 2'd3 : 2'd1));
        word      = q_head.copies[copy_reg];
        q_pop     = load && job_done;

        byte_next      = byte_reg;
        copy_next      = copy_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_data_next.data_byte = word[{byte_reg, 3'b000} +: 8] ^ {8{cfg.invert_output}};
            out_data_next.last_byte = job_done;
            out_valid_next          = 1'b1;
            if (job_done)
            begin
                byte_next = '0;
                copy_next = '0;
            end
            else if (copy_done)
            begin
                byte_next = '0;
                copy_next = copy_reg + 1'b1;
            end
            else
            begin
                byte_next = byte_reg + 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg      <= '0;
            copy_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            byte_reg      <= byte_next;
            copy_reg      <= copy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

`ifndef SYNTH
    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (out_valid_reg && out_data_reg.last_byte))
        else $error("job retired without last byte");
    a_pop_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (byte_reg == 2'd0 && copy_reg == 2'd0))
        else $error("serializer counters not rewound after job");
    a_short_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !cfg.tall_font) |-> (byte_reg <= 2'd1))
        else $error("byte index beyond short copy");
`endif

endmodule

`default_nettype wire

/* hw/rtl/glyph_double_size_smoother.sv */
`default_nettype none

// Channel  Direction  Payload                          Handshake
// in       input      in_item_t  {column_bits, last}   in_valid / in_ready
// out      output     out_item_t {data_byte, last}     out_valid / out_ready
// cfg      input      cfg_index (2b), cfg_data (1b)    cfg_valid / cfg_ready
//
// Output runs at one byte per cycle from the back-end serializer while a job is
// queued and out_ready allows. Plain mode: 8 bytes per column with tall font
// (4 short), 16 (8) when a held column is flushed first. Smooth mode: a glyph's
// first column gives none, later ones 8 (4), the last 16 (8), a sole one 8 (4).
// Reset clears the column hold, queue and serializer; cfg is always ready.
// The front takes a column whenever the job queue has room.

module glyph_double_size_smoother
    import gdss_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire  logic       clk,
    input  wire  logic       rst_n,
    input  wire  logic       in_valid,
    output logic             in_ready,
    input  wire  in_item_t   in_data,
    output logic             out_valid,
    input  wire  logic       out_ready,
    output out_item_t        out_data,
    input  wire  logic       cfg_valid,
    output logic             cfg_ready,
    input  wire  logic [1:0] cfg_index,
    input  wire  logic       cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    job_t q_data;
    job_t q_head;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SMOOTH_MODE:   cfg_next.smooth_mode   = cfg_data;
                CFG_TALL_FONT:     cfg_next.tall_font     = cfg_data;
                CFG_INVERT_OUTPUT: cfg_next.invert_output = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smooth_mode   <= 1'b0;
            cfg_reg.tall_font     <= 1'b1;
            cfg_reg.invert_output <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gdss_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_data)
    );

    gdss_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    gdss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
